>>> sv/sac_pkg.sv
// Package for the compacting segment allocator: table sizes, codes and beat types.
// No dependencies; every other file imports it.
package sac_pkg;

  localparam int unsigned MaxSegments = 32;
  localparam int unsigned IdxW = $clog2(MaxSegments);
  localparam int unsigned CntW = $clog2(MaxSegments + 1);
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW = 21;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] FuncAlloc   = 2'd0;
  localparam logic [1:0] FuncFree    = 2'd1;
  localparam logic [1:0] FuncCompact = 2'd2;

  localparam logic [2:0] StAllocOk   = 3'd0;
  localparam logic [2:0] StAllocFail = 3'd1;
  localparam logic [2:0] StFreed     = 3'd2;
  localparam logic [2:0] StNotFound  = 3'd3;
  localparam logic [2:0] StMove      = 3'd4;
  localparam logic [2:0] StCompDone  = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgMemBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMemSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFitMode = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [LenW-1:0]  size;
    logic [AddrW-1:0] base;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [AddrW-1:0] seg_address;
    logic [AddrW-1:0] old_address;
    logic [LenW-1:0]  length;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [AddrW-1:0]   data;
  } cfg_t;

endpackage

>>> sv/sac_if.sv
// Valid/ready channel interface carrying one payload type per beat.
// Depends on sac_pkg for the payload types.
interface sac_req_if;
  import sac_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sac_rsp_if;
  import sac_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sac_cfg_if;
  import sac_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/segment_allocator_compacting.sv
// Compacting segment allocator; one request at a time, table walked one entry a cycle
// while no result beat is stalled. Free walks to the matching base; alloc scans, picks,
// shifts entries up for a split, emits and waits. A miss adds a compaction and a second
// scan, pick and split. Compact walks the table, emits a done beat and clears used bits
// above the new count. The next request is taken once the last beat has left.
// Reset (rst_ni low, async) sets one free segment of 4096 bytes at address 0.
module segment_allocator_compacting (
  input logic clk_i,
  input logic rst_ni,
  sac_cfg_if.sink    cfg_i,
  sac_req_if.sink    req_i,
  sac_rsp_if.source  rsp_o
);
  import sac_pkg::*;

  typedef enum logic [9:0] {
    SIdle    = 10'b0000000001,
    SScan    = 10'b0000000010,
    SPick    = 10'b0000000100,
    SShift   = 10'b0000001000,
    SFree    = 10'b0000010000,
    SComp    = 10'b0000100000,
    SCompEnd = 10'b0001000000,
    SClear   = 10'b0010000000,
    SEmit    = 10'b0100000000,
    SWaitOut = 10'b1000000000
  } state_e;

  state_e state_q;

  // segment table in flip-flops, walked through the walk index i_q
  logic [AddrW-1:0] eb_q [MaxSegments];
  logic [LenW-1:0]  el_q [MaxSegments];
  logic [MaxSegments-1:0] eu_q;
  logic [CntW-1:0] cnt_q;

  logic [AddrW-1:0] mbase_q;
  logic [LenW-1:0]  msize_q;
  logic             fit_q;

  req_t req_q;
  logic retry_q;             // second alloc pass after compaction
  logic [CntW-1:0] i_q;      // walk index
  logic [CntW-1:0] w_q;      // compaction write index
  logic [CntW-1:0] pick_q;
  logic pick_vld_q;
  logic [AddrW-1:0] next_q;
  logic [LenW:0]    usum_q;

  rsp_t out_q;
  logic out_vld_q;
  state_e after_q;           // state that SWaitOut moves to next

  logic [IdxW-1:0] ii, wi, pi;
  assign ii = i_q[IdxW-1:0];
  assign wi = w_q[IdxW-1:0];
  assign pi = pick_q[IdxW-1:0];

  logic idle;
  assign idle = (state_q == SIdle) && !out_vld_q;
  assign cfg_i.ready = idle;
  assign req_i.ready = idle && !cfg_i.valid;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  logic out_free;
  assign out_free = !out_vld_q || rsp_o.ready;

  // compare unit for the scan: fits test on the walked entry
  logic fits, better;
  assign fits   = !eu_q[ii] && (el_q[ii] >= req_q.size);
  assign better = !pick_vld_q || (fit_q && (el_q[ii] < el_q[pi]));

  logic [LenW:0] tail_full;
  assign tail_full = {1'b0, msize_q} - usum_q;

  // a result beat is loaded this cycle
  logic out_set;
  assign out_set =
      ((state_q == SIdle) && req_i.valid && req_i.ready &&
       (req_i.data.func == FuncAlloc) && (req_i.data.size == '0)) ||
      ((state_q == SComp) && (i_q != cnt_q) && eu_q[ii] && out_free &&
       (eb_q[ii] != next_q)) ||
      (((state_q == SCompEnd) || (state_q == SEmit)) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      after_q    <= SIdle;
      out_vld_q  <= 1'b0;
      mbase_q    <= '0;
      msize_q    <= LenW'(4096);
      fit_q      <= 1'b0;
      cnt_q      <= CntW'(1);
      eu_q       <= '0;
      eb_q[0]    <= '0;
      el_q[0]    <= LenW'(4096);
      retry_q    <= 1'b0;
      pick_vld_q <= 1'b0;
    end else begin
      if (out_set) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cfg_i.valid && cfg_i.ready) begin
            if (cfg_i.data.index == CfgMemBase || cfg_i.data.index == CfgMemSize) begin
              eu_q  <= '0;
              cnt_q <= CntW'(1);
              eb_q[0] <= (cfg_i.data.index == CfgMemBase) ? cfg_i.data.data : mbase_q;
              el_q[0] <= (cfg_i.data.index == CfgMemSize) ? cfg_i.data.data[LenW-1:0]
                                                           : msize_q;
            end
            if (cfg_i.data.index == CfgMemBase) mbase_q <= cfg_i.data.data;
            if (cfg_i.data.index == CfgMemSize) msize_q <= cfg_i.data.data[LenW-1:0];
            if (cfg_i.data.index == CfgFitMode) fit_q <= cfg_i.data.data[0];
          end else if (req_i.valid && req_i.ready) begin
            req_q      <= req_i.data;
            i_q        <= '0;
            retry_q    <= 1'b0;
            pick_vld_q <= 1'b0;
            unique case (req_i.data.func)
              FuncAlloc: begin
                if (req_i.data.size == '0) begin
                  out_q <= '{StAllocFail, '0, '0, '0, 1'b1};
                end else begin
                  state_q <= SScan;
                end
              end
              FuncFree: state_q <= SFree;
              FuncCompact: begin
                state_q <= SComp;
                w_q     <= '0;
                next_q  <= mbase_q;
                usum_q  <= '0;
              end
              default: state_q <= SIdle;
            endcase
          end
        end
        SScan: begin
          if (i_q == cnt_q || (pick_vld_q && !fit_q)) begin
            state_q <= SPick;
          end else begin
            if (fits && better) begin
              pick_q     <= i_q;
              pick_vld_q <= 1'b1;
            end
            i_q <= i_q + 1'b1;
          end
        end
        SPick: begin
          // wait until a pending compaction done beat has left
          if (!out_vld_q) begin
            if (pick_vld_q && el_q[pi] == req_q.size) begin
              eu_q[pi] <= 1'b1;
              out_q    <= '{StAllocOk, eb_q[pi], '0, req_q.size, 1'b1};
              state_q  <= SEmit;
            end else if (pick_vld_q && cnt_q < CntW'(MaxSegments)) begin
              i_q     <= cnt_q;
              state_q <= SShift;
            end else if (retry_q) begin
              out_q   <= '{StAllocFail, '0, '0, req_q.size, 1'b1};
              state_q <= SEmit;
            end else begin
              retry_q <= 1'b1;
              state_q <= SComp;
              i_q     <= '0;
              w_q     <= '0;
              next_q  <= mbase_q;
              usum_q  <= '0;
            end
          end
        end
        SShift: begin
          // one entry moves up per cycle, then the split is written
          if (i_q > pick_q + 1'b1) begin
            eb_q[ii] <= eb_q[ii - 1'b1];
            el_q[ii] <= el_q[ii - 1'b1];
            eu_q[ii] <= eu_q[ii - 1'b1];
            i_q      <= i_q - 1'b1;
          end else begin
            eb_q[ii] <= eb_q[pi] + AddrW'(req_q.size);
            el_q[ii] <= el_q[pi] - req_q.size;
            eu_q[ii] <= 1'b0;
            el_q[pi] <= req_q.size;
            eu_q[pi] <= 1'b1;
            cnt_q    <= cnt_q + 1'b1;
            out_q    <= '{StAllocOk, eb_q[pi], '0, req_q.size, 1'b1};
            state_q  <= SEmit;
          end
        end
        SFree: begin
          if (i_q == cnt_q) begin
            out_q   <= '{StNotFound, req_q.base, '0, '0, 1'b1};
            state_q <= SEmit;
          end else if (eb_q[ii] == req_q.base) begin
            eu_q[ii] <= 1'b0;
            out_q    <= '{StFreed, req_q.base, '0, el_q[ii], 1'b1};
            state_q  <= SEmit;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        SComp: begin
          if (i_q == cnt_q) begin
            state_q <= SCompEnd;
          end else if (!eu_q[ii]) begin
            i_q <= i_q + 1'b1;
          end else if (out_free) begin
            if (eb_q[ii] != next_q) begin
              out_q <= '{StMove, next_q, eb_q[ii], el_q[ii], 1'b0};
            end
            eb_q[wi] <= next_q;
            el_q[wi] <= el_q[ii];
            eu_q[wi] <= 1'b1;
            next_q   <= next_q + AddrW'(el_q[ii]);
            usum_q   <= usum_q + {1'b0, el_q[ii]};
            w_q      <= w_q + 1'b1;
            i_q      <= i_q + 1'b1;
          end
        end
        SCompEnd: begin
          if (out_free) begin
            if (w_q < CntW'(MaxSegments)) begin
              eb_q[wi] <= next_q;
              el_q[wi] <= tail_full[LenW] ? '0 : tail_full[LenW-1:0];
              eu_q[wi] <= 1'b0;
              out_q <= '{StCompDone, next_q, '0,
                         tail_full[LenW] ? '0 : tail_full[LenW-1:0], !retry_q};
              cnt_q <= w_q + 1'b1;
              i_q   <= w_q + 1'b1;
            end else begin
              out_q <= '{StCompDone, next_q, '0, '0, !retry_q};
              cnt_q <= w_q;
              i_q   <= w_q;
            end
            state_q <= SClear;
          end
        end
        SClear: begin
          // clear stale used bits above the new count, one per cycle
          if (i_q >= CntW'(MaxSegments)) begin
            i_q        <= '0;
            pick_vld_q <= 1'b0;
            state_q    <= retry_q ? SScan : SIdle;
          end else begin
            eu_q[ii] <= 1'b0;
            i_q      <= i_q + 1'b1;
          end
        end
        SEmit: begin
          if (out_free) begin
            state_q <= SWaitOut;
            after_q <= SIdle;
          end
        end
        SWaitOut: state_q <= after_q;
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSegments)) else $error("entry count overflow");
  a_busy_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !req_i.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !rsp_o.ready) |=> (out_vld_q && $stable(out_q)))
    else $error("pending beat lost");
`endif

endmodule
